[design/scc_pkg.sv]
package scc_pkg;

    // vertex numbers inside the solver (room for a count up to 127)
    localparam int VXW = 7;
    // vertex field width on the stream
    localparam int VFW = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OUTER,
        ST_SCAN,
        ST_EDGE,
        ST_STACK_RD,
        ST_FIN_POP,
        ST_FIN_RD,
        ST_DONE
    } t_state;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_SOLVE = 1'b1
    } t_op;

    typedef enum logic {
        PH_FORWARD = 1'b0,
        PH_REVERSE = 1'b1
    } t_phase;

endpackage

[design/count_strongly_connected_components_core.sv]
// channel | direction | tdata (low bit up)                      | tuser
// s_axis  | in        | source_vertex[5:0], target_vertex[11:6] | op
// m_axis  | out       | component_count[6:0], edges_dropped[7]  | -
// cfg     | in        | vertex_count[6:0] on i_cfg_we           | -
//
// an add-edge item leaves the core in idle, so the next item can follow right away.
// a solve item scans the edge store through the scan and edge states for every
// vertex in both depth-first passes, bounded by the single read port of the edge
// memory; input stalls until the result is registered.
// reset (synchronous, active low) clears the edge count, drop flag, visited
// marks and handshake state; the memories need no clearing.
// a solve waits in its last state while a previous result is still untaken.
module count_strongly_connected_components_core
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,      // vertex_count
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // source_vertex[5:0], target_vertex[11:6]
    input  logic        i_s_axis_tuser,  // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata   // component_count[6:0], edges_dropped[7]
);

    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SPW = $clog2(MAX_VERTICES + 1);
    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int STW = VXW + EW;

    t_state n_state, r_state;
    logic [6:0]     r_vc;
    logic [EW-1:0]  r_total, n_total;
    logic           r_drop, n_drop;
    t_phase         r_phase, n_phase;
    logic [VXW-1:0] r_ov, n_ov;
    logic [VXW-1:0] r_cur_v, n_cur_v;
    logic [EW-1:0]  r_cur_i, n_cur_i;
    logic [SPW-1:0] r_sp, n_sp;
    logic [SPW-1:0] r_ftop, n_ftop;
    logic [6:0]     r_count, n_count;
    logic [MAX_VERTICES-1:0] r_visited;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_data, n_out_data;

    // memories
    logic [2*VFW-1:0] r_edge_mem [MAX_EDGES];
    logic [STW-1:0]   r_stack_mem [MAX_VERTICES];
    logic [VXW-1:0]   r_fin_mem [MAX_VERTICES];
    logic [2*VFW-1:0] r_em_q;
    logic [STW-1:0]   r_st_q;
    logic [VXW-1:0]   r_fo_q;

    logic             em_we, st_we, fo_we;
    logic [AW-1:0]    em_wa, em_ra;
    logic [2*VFW-1:0] em_wd;
    logic [IW-1:0]    st_wa, st_ra, fo_wa, fo_ra;
    logic [STW-1:0]   st_wd;
    logic [VXW-1:0]   fo_wd;

    logic           vis_clr, vis_set, vis_rd;
    logic [IW-1:0]  vis_sidx, vis_ridx;

    logic           in_acc;
    logic [6:0]     n_live;
    logic [VXW-1:0] in_src, in_dst, e_from, e_to;
    logic           e_match;
    logic [SPW-1:0] sp_dec, sp_dec2, ftop_dec;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // effective vertex count
    assign n_live = ({25'b0, r_vc} > 32'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : r_vc;

    assign in_src = {1'b0, i_s_axis_tdata[VFW-1:0]};
    assign in_dst = {1'b0, i_s_axis_tdata[2*VFW-1:VFW]};

    // edge endpoints in the direction of the current pass
    assign e_from = (r_phase == PH_REVERSE) ? {1'b0, r_em_q[2*VFW-1:VFW]}
                                            : {1'b0, r_em_q[VFW-1:0]};
    assign e_to   = (r_phase == PH_REVERSE) ? {1'b0, r_em_q[VFW-1:0]}
                                            : {1'b0, r_em_q[2*VFW-1:VFW]};

    assign sp_dec   = r_sp - SPW'(1);
    assign sp_dec2  = r_sp - SPW'(2);
    assign ftop_dec = r_ftop - SPW'(1);

    // visited mark lookup, one address per state
    always_comb begin
        unique case (r_state)
            ST_OUTER: vis_ridx = IW'(r_ov);
            ST_FIN_RD: vis_ridx = IW'(r_fo_q);
            default: vis_ridx = IW'(e_to);
        endcase
    end
    assign vis_rd = r_visited[vis_ridx];

    assign e_match = (e_from == r_cur_v) && (e_to < n_live) && (e_from < n_live)
                     && !vis_rd;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (t_op'(i_s_axis_tuser) == OP_SOLVE)) n_state = ST_OUTER;
            end
            ST_OUTER: begin
                if (r_ov >= n_live) n_state = ST_FIN_POP;
                else if (!vis_rd) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cur_i >= r_total) begin
                    if (r_sp == SPW'(1))
                        n_state = (r_phase == PH_REVERSE) ? ST_FIN_POP : ST_OUTER;
                    else
                        n_state = ST_STACK_RD;
                end else begin
                    n_state = ST_EDGE;
                end
            end
            ST_EDGE: n_state = ST_SCAN;
            ST_STACK_RD: n_state = ST_SCAN;
            ST_FIN_POP: n_state = (r_ftop == '0) ? ST_DONE : ST_FIN_RD;
            ST_FIN_RD: begin
                if ((r_fo_q < n_live) && !vis_rd) n_state = ST_SCAN;
                else n_state = ST_FIN_POP;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_total = r_total;
        n_drop = r_drop;
        n_phase = r_phase;
        n_ov = r_ov;
        n_cur_v = r_cur_v;
        n_cur_i = r_cur_i;
        n_sp = r_sp;
        n_ftop = r_ftop;
        n_count = r_count;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data = r_out_data;
        em_we = 1'b0;
        em_wa = r_total[AW-1:0];
        em_wd = i_s_axis_tdata[2*VFW-1:0];
        em_ra = r_cur_i[AW-1:0];
        st_we = 1'b0;
        st_wa = sp_dec[IW-1:0];
        st_wd = {r_cur_v, r_cur_i};
        st_ra = sp_dec2[IW-1:0];
        fo_we = 1'b0;
        fo_wa = r_ftop[IW-1:0];
        fo_wd = r_cur_v;
        fo_ra = ftop_dec[IW-1:0];
        vis_clr = 1'b0;
        vis_set = 1'b0;
        vis_sidx = IW'(r_ov);
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (t_op'(i_s_axis_tuser) == OP_ADD) begin
                        if ((r_total == EW'(MAX_EDGES)) || (in_src >= n_live)
                            || (in_dst >= n_live)) begin
                            n_drop = 1'b1;
                        end else begin
                            em_we = 1'b1;
                            n_total = r_total + EW'(1);
                        end
                    end else begin
                        vis_clr = 1'b1;
                        n_ftop = '0;
                        n_phase = PH_FORWARD;
                        n_ov = '0;
                        n_count = '0;
                    end
                end
            end
            // forward pass: next root in vertex order
            ST_OUTER: begin
                if (r_ov >= n_live) begin
                    n_phase = PH_REVERSE;
                    vis_clr = 1'b1;
                end else if (vis_rd) begin
                    n_ov = r_ov + VXW'(1);
                end else begin
                    vis_set = 1'b1;
                    vis_sidx = IW'(r_ov);
                    n_cur_v = r_ov;
                    n_cur_i = '0;
                    n_sp = SPW'(1);
                end
            end
            // fetch next edge or finish the top vertex
            ST_SCAN: begin
                if (r_cur_i >= r_total) begin
                    if ((r_phase == PH_FORWARD) && (r_ftop < SPW'(MAX_VERTICES))) begin
                        fo_we = 1'b1;
                        n_ftop = r_ftop + SPW'(1);
                    end
                    n_sp = sp_dec;
                    if ((r_sp == SPW'(1)) && (r_phase == PH_FORWARD))
                        n_ov = r_ov + VXW'(1);
                end else begin
                    n_cur_i = r_cur_i + EW'(1);
                end
            end
            // follow the edge if it leads to an unvisited vertex
            ST_EDGE: begin
                if (e_match && (r_sp < SPW'(MAX_VERTICES))) begin
                    st_we = 1'b1;
                    vis_set = 1'b1;
                    vis_sidx = IW'(e_to);
                    n_cur_v = e_to;
                    n_cur_i = '0;
                    n_sp = r_sp + SPW'(1);
                end
            end
            ST_STACK_RD: begin
                n_cur_v = r_st_q[STW-1:EW];
                n_cur_i = r_st_q[EW-1:0];
            end
            ST_FIN_POP: begin
                if (r_ftop != '0) n_ftop = ftop_dec;
            end
            // reverse pass: new component from an unvisited vertex
            ST_FIN_RD: begin
                if ((r_fo_q < n_live) && !vis_rd) begin
                    n_count = r_count + 7'd1;
                    vis_set = 1'b1;
                    vis_sidx = IW'(r_fo_q);
                    n_cur_v = r_fo_q;
                    n_cur_i = '0;
                    n_sp = SPW'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data = {r_drop, r_count};
                    n_total = '0;
                    n_drop = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vc <= 7'd64;
            r_total <= '0;
            r_drop <= 1'b0;
            r_phase <= PH_FORWARD;
            r_ov <= '0;
            r_sp <= '0;
            r_ftop <= '0;
            r_count <= '0;
            r_visited <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_vc <= i_cfg_data;
            r_total <= n_total;
            r_drop <= n_drop;
            r_phase <= n_phase;
            r_ov <= n_ov;
            r_sp <= n_sp;
            r_ftop <= n_ftop;
            r_count <= n_count;
            r_out_valid <= n_out_valid;
            if (vis_clr) r_visited <= '0;
            else if (vis_set) r_visited[vis_sidx] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur_v <= n_cur_v;
        r_cur_i <= n_cur_i;
        r_out_data <= n_out_data;
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (em_we) r_edge_mem[em_wa] <= em_wd;
        r_em_q <= r_edge_mem[em_ra];
    end

    // walk stack, entries below the top
    always_ff @(posedge i_clk) begin
        if (st_we) r_stack_mem[st_wa] <= st_wd;
        r_st_q <= r_stack_mem[st_ra];
    end

    // finishing order
    always_ff @(posedge i_clk) begin
        if (fo_we) r_fin_mem[fo_wa] <= fo_wd;
        r_fo_q <= r_fin_mem[fo_ra];
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(MAX_VERTICES))
        else $error("walk stack overflow");

    a_ftop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ftop <= SPW'(MAX_VERTICES))
        else $error("finish order overflow");

    a_scan_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_sp != '0))
        else $error("scan with empty stack");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= EW'(MAX_EDGES))
        else $error("edge count beyond store");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |=> (r_total == '0 && o_m_axis_tvalid))
        else $error("solve did not clear store");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
    import scc_pkg::*;
;

    localparam int NV        = 64;
    localparam int NE        = 256;
    localparam int WDOG_MAX  = 400000;
    localparam int EXP_DEPTH = 64;

    // dropped flag sits in the top bit, as on tdata
    typedef struct packed {
        logic       dropped;
        logic [6:0] comps;
    } t_scc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;

    // graph mirror used to predict component counts
    logic [5:0]  g_src [NE];
    logic [5:0]  g_dst [NE];
    int          g_edges;
    bit          g_dropped;
    logic [6:0]  g_vcount;
    bit          seen [NV];
    int          fin_ord [NV];
    int          fin_top;
    int          stk_v [NV];
    int          stk_i [NV];

    // expected results, written on accept and read on each result
    t_scc_result exp_mem [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    int          fail_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          quiet_cycles;

    count_strongly_connected_components_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // iterative depth-first walk, forward or over reversed edges
    function automatic void dfs_walk(int start, bit rev, bit rec, int n);
        int sp, v, i, fr, to;
        bit pushed;
        sp = 1;
        seen[start] = 1'b1;
        stk_v[0] = start;
        stk_i[0] = 0;
        while (sp > 0) begin
            v = stk_v[sp-1];
            i = stk_i[sp-1];
            pushed = 1'b0;
            while (i < g_edges) begin
                fr = rev ? g_dst[i] : g_src[i];
                to = rev ? g_src[i] : g_dst[i];
                i++;
                if (fr == v && to < n && fr < n && !seen[to]) begin
                    stk_i[sp-1] = i;
                    if (sp < NV) begin
                        seen[to] = 1'b1;
                        stk_v[sp] = to;
                        stk_i[sp] = 0;
                        sp++;
                        pushed = 1'b1;
                    end
                    break;
                end
            end
            if (!pushed && i >= g_edges) begin
                sp--;
                if (rec && fin_top < NV) begin
                    fin_ord[fin_top] = v;
                    fin_top++;
                end
            end
        end
    endfunction

    // apply one accepted item to the graph mirror
    function automatic void graph_apply(t_op op, logic [5:0] src, logic [5:0] dst);
        int n, v, comps;
        t_scc_result r;
        n = (g_vcount > NV) ? NV : int'(g_vcount);
        if (op == OP_ADD) begin
            if (g_edges >= NE || src >= n || dst >= n) begin
                g_dropped = 1'b1;
            end else begin
                g_src[g_edges] = src;
                g_dst[g_edges] = dst;
                g_edges++;
            end
            return;
        end
        comps = 0;
        foreach (seen[k]) seen[k] = 1'b0;
        fin_top = 0;
        for (v = 0; v < n; v++)
            if (!seen[v]) dfs_walk(v, 1'b0, 1'b1, n);
        foreach (seen[k]) seen[k] = 1'b0;
        while (fin_top > 0) begin
            fin_top--;
            v = fin_ord[fin_top];
            if (v < n && !seen[v]) begin
                comps++;
                dfs_walk(v, 1'b1, 1'b0, n);
            end
        end
        r.comps = comps[6:0];
        r.dropped = g_dropped;
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
        g_edges = 0;
        g_dropped = 1'b0;
    endfunction

    // result side: check, then pick next tready
    always @(posedge i_clk) begin
        t_scc_result got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (exp_wr == exp_rd) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: comps=%0d dropped=%0b",
                                 got.comps, got.dropped);
                end else begin
                    want = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (got.comps !== want.comps || got.dropped !== want.dropped) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: comps exp %0d got %0d, dropped exp %0b got %0b",
                                     want.comps, got.comps, want.dropped, got.dropped);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // send one item, at times with a random gap first; called at a clock edge
    task automatic send_item(t_op op, logic [5:0] src, logic [5:0] dst);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'b0, dst, src};
        do @(posedge i_clk); while (!o_s_axis_tready);
        graph_apply(op, src, dst);
    endtask

    // drop valid and wait until every result is in
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_vcount(logic [6:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        g_vcount = val;
    endtask

    // extremes, every op, each special case
    task automatic test_directed();
        send_item(OP_SOLVE, 6'd0, 6'd0);          // empty graph at reset count
        send_item(OP_ADD, 6'd0, 6'd63);
        send_item(OP_ADD, 6'd63, 6'd0);
        send_item(OP_ADD, 6'd5, 6'd5);            // self loop
        send_item(OP_ADD, 6'd42, 6'd21);
        send_item(OP_SOLVE, 6'd63, 6'd63);
        settle();
        write_vcount(7'd0);                       // every edge dropped
        send_item(OP_ADD, 6'd0, 6'd0);
        send_item(OP_SOLVE, 6'd0, 6'd0);
        settle();
        write_vcount(7'd127);                     // capped at the vertex limit
        send_item(OP_ADD, 6'd63, 6'd62);
        send_item(OP_ADD, 6'd62, 6'd63);
        send_item(OP_SOLVE, 6'd0, 6'd0);
        settle();
        write_vcount(7'd1);
        send_item(OP_ADD, 6'd0, 6'd0);
        send_item(OP_ADD, 6'd0, 6'd1);            // endpoint out of range
        send_item(OP_SOLVE, 6'd0, 6'd0);
        settle();
        // count lowered after loading
        write_vcount(7'd64);
        send_item(OP_ADD, 6'd0, 6'd40);
        send_item(OP_ADD, 6'd40, 6'd0);
        send_item(OP_ADD, 6'd1, 6'd2);
        send_item(OP_ADD, 6'd2, 6'd1);
        settle();
        write_vcount(7'd10);
        send_item(OP_SOLVE, 6'd0, 6'd0);
        settle();
    endtask

    // fill the store past its capacity
    task automatic test_store_full();
        int k;
        write_vcount(7'd64);
        for (k = 0; k < NE + 4; k++)
            send_item(OP_ADD, 6'($urandom_range(63)), 6'($urandom_range(63)));
        send_item(OP_SOLVE, 6'd0, 6'd0);
        settle();
    endtask

    // random graphs: mostly valid edges, some out of range and noise
    task automatic test_random_graphs(int items);
        int sent, k, ne, n, pick;
        logic [6:0] vc;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 60)      vc = 7'($urandom_range(1, 8));
            else if (pick < 80) vc = 7'($urandom_range(9, 63));
            else if (pick < 90) vc = 7'd64;
            else if (pick < 95) vc = 7'($urandom_range(65, 127));
            else                vc = 7'd0;
            write_vcount(vc);
            n = (vc > NV) ? NV : (vc == 0 ? 1 : int'(vc));
            ne = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 14);
            for (k = 0; k < ne; k++) begin
                if ($urandom_range(9) == 0)
                    send_item(OP_ADD, 6'($urandom), 6'($urandom));
                else
                    send_item(OP_ADD, 6'($urandom_range(n - 1)), 6'($urandom_range(n - 1)));
                sent++;
            end
            send_item(OP_SOLVE, 6'($urandom), 6'($urandom));
            sent++;
            settle();
        end
    endtask

    // receiver holds off while solves queue up behind the result
    task automatic test_backpressure();
        int g, k;
        write_vcount(7'd6);
        hold_cycles = 600;
        for (g = 0; g < 4; g++) begin
            for (k = 0; k < 6; k++)
                send_item(OP_ADD, 6'($urandom_range(5)), 6'($urandom_range(5)));
            send_item(OP_SOLVE, 6'd0, 6'd0);
        end
        settle();
    endtask

    initial begin
        fail_cnt        = 0;
        exp_wr          = 0;
        exp_rd          = 0;
        hold_cycles     = 0;
        quiet_cycles    = 0;
        send_idle_pct   = 9;
        recv_idle_pct   = 72;
        g_edges         = 0;
        g_dropped       = 1'b0;
        g_vcount        = 7'd64;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = 7'd0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 16'd0;
        i_s_axis_tuser  = OP_ADD;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_full();
        test_random_graphs(340);
        send_idle_pct = 72;
        recv_idle_pct = 9;
        test_random_graphs(340);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_graphs(340);

        settle();
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0 && exp_wr == exp_rd)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
